FILE: hdl/stx_len_etx_xor_frame_echo_defines.svh
// Assertion macros shared by the frame echo checker.
// No dependencies; take in by `include before use.
`ifndef STX_LEN_ETX_XOR_FRAME_ECHO_DEFINES_SVH
`define STX_LEN_ETX_XOR_FRAME_ECHO_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define STXECHO_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define STXECHO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/stxecho_pkg.sv
// Shared types and constants for the STX/LEN/ETX frame echo block.
// No dependencies.
package stxecho_pkg;

  localparam int LenW = 6;
  localparam int ByteW = 8;
  localparam int MaxPayloadDefault = 60;
  localparam int QueueDepth = 2;

  localparam logic [ByteW-1:0] StxByte = 8'h02;
  localparam logic [ByteW-1:0] EtxByte = 8'h03;

  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] chk;
    logic             sel;
  } frame_cmd_t;

  typedef struct packed {
    logic             en;
    logic             sel;
    logic [LenW-1:0]  idx;
    logic [ByteW-1:0] data;
  } pay_wr_t;

endpackage

FILE: hdl/stxecho_front.sv
// Frame parser: hunts for STX, checks length, ETX and XOR check byte.
// Writes payload bytes to the back end's buffer; uses stxecho_pkg.
module stxecho_front #(
  parameter int MAX_PAYLOAD = stxecho_pkg::MaxPayloadDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              rx_byte,
  input  logic                    q_full,
  output logic                    push,
  output stxecho_pkg::frame_cmd_t cmd,
  output stxecho_pkg::pay_wr_t    wr
);
  import stxecho_pkg::*;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_END     = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;

  logic [2:0]       phase;
  logic [LenW-1:0]  exp_len;
  logic [LenW-1:0]  idx;
  logic [LenW-1:0]  idx_next;
  logic [ByteW-1:0] run_xor;
  logic             wr_sel;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign idx_next = idx + LenW'(1);

  assign push     = accept && (phase == PH_CHECK) && (rx_byte == run_xor);
  assign cmd.len  = exp_len;
  assign cmd.chk  = run_xor;
  assign cmd.sel  = wr_sel;

  assign wr.en    = accept && (phase == PH_PAYLOAD);
  assign wr.sel   = wr_sel;
  assign wr.idx   = idx;
  assign wr.data  = rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      exp_len <= '0;
      idx     <= '0;
      run_xor <= '0;
      wr_sel  <= 1'b0;
    end else if (accept) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == StxByte) begin
            phase   <= PH_LENGTH;
            run_xor <= rx_byte;
            idx     <= '0;
          end
        end
        PH_LENGTH: begin
          run_xor <= run_xor ^ rx_byte;
          if (rx_byte > ByteW'(MAX_PAYLOAD)) begin
            phase <= PH_HUNT;
          end else begin
            exp_len <= rx_byte[LenW-1:0];
            idx     <= '0;
            phase   <= (rx_byte == '0) ? PH_END : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          run_xor <= run_xor ^ rx_byte;
          idx     <= idx_next;
          if (idx_next >= exp_len) begin
            phase <= PH_END;
          end
        end
        PH_END: begin
          if (rx_byte == EtxByte) begin
            run_xor <= run_xor ^ rx_byte;
            phase   <= PH_CHECK;
          end else begin
            phase <= PH_HUNT;
          end
        end
        PH_CHECK: begin
          if (push) begin
            wr_sel <= !wr_sel;
          end
          phase <= PH_HUNT;
        end
        default: begin
          phase <= PH_HUNT;
        end
      endcase
    end
  end

endmodule

FILE: hdl/stxecho_queue.sv
// Two-entry queue of validated frame requests between parser and emitter.
// Uses stxecho_pkg.
module stxecho_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  stxecho_pkg::frame_cmd_t push_cmd,
  input  logic                    pop,
  output stxecho_pkg::frame_cmd_t head,
  output logic                    empty,
  output logic                    full
);
  import stxecho_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  frame_cmd_t      entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CntW'(QueueDepth));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

FILE: hdl/stxecho_back.sv
// Response emitter with the two-bank payload buffer and output register.
// Uses stxecho_pkg.
module stxecho_back #(
  parameter int MAX_PAYLOAD = stxecho_pkg::MaxPayloadDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  stxecho_pkg::pay_wr_t    wr,
  input  stxecho_pkg::frame_cmd_t head,
  input  logic                    empty,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              tx_byte,
  output logic                    frame_last
);
  import stxecho_pkg::*;

  localparam int BufDepth = 2 * MAX_PAYLOAD;
  localparam int AddrW = $clog2(BufDepth);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STX  = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_PAY  = 3'd4;
  localparam logic [2:0] S_ETX  = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;

  logic [ByteW-1:0] mem [BufDepth];
  logic [ByteW-1:0] rdata;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic [2:0]       state;
  logic [LenW-1:0]  idx;
  logic [LenW-1:0]  idx_next;
  logic             load;
  logic             emit;

  assign waddr = wr.sel ? AddrW'(wr.idx) + AddrW'(MAX_PAYLOAD) : AddrW'(wr.idx);
  assign raddr = head.sel ? AddrW'(idx) + AddrW'(MAX_PAYLOAD) : AddrW'(idx);

  assign load     = !out_valid || !out_stall;
  assign emit     = load && (state inside {S_STX, S_LEN, S_PAY, S_ETX, S_CHK});
  assign idx_next = idx + LenW'(1);
  assign pop      = (state == S_CHK) && load;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
    if (state == S_RD) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= emit;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            state <= S_STX;
          end
        end
        S_STX: begin
          if (load) begin
            tx_byte    <= StxByte;
            frame_last <= 1'b0;
            state      <= S_LEN;
          end
        end
        S_LEN: begin
          if (load) begin
            tx_byte    <= ByteW'(head.len);
            frame_last <= 1'b0;
            idx        <= '0;
            state      <= (head.len == '0) ? S_ETX : S_RD;
          end
        end
        S_RD: begin
          state <= S_PAY;
        end
        S_PAY: begin
          if (load) begin
            tx_byte    <= rdata;
            frame_last <= 1'b0;
            idx        <= idx_next;
            state      <= (idx_next == head.len) ? S_ETX : S_RD;
          end
        end
        S_ETX: begin
          if (load) begin
            tx_byte    <= EtxByte;
            frame_last <= 1'b0;
            state      <= S_CHK;
          end
        end
        S_CHK: begin
          if (load) begin
            tx_byte    <= head.chk;
            frame_last <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/stx_len_etx_xor_frame_echo.sv
// STX/LEN/ETX frame receiver with XOR check, echoing each valid frame.
// Input channel in_valid/in_stall/rx_byte takes one received byte per request.
// Output channel out_valid/out_stall/tx_byte/frame_last gives one response
// byte per request; frame_last marks the check byte that ends a response.
// Frames with a length above MAX_PAYLOAD, a wrong ETX or a bad check byte
// are dropped without output.
// Input: one byte per cycle while the request queue has room. in_stall rises
// only while the queue holds two validated frames, the one being echoed among
// them; the parser, the queue and the emitter each hold their own state, so
// parsing continues while a response is sent.
// Response start: the taken check byte pushes the request into the queue; the
// emitter then goes to S_STX and loads STX into the output register.
// Emitter steps: S_IDLE, S_STX, S_LEN, S_RD and S_PAY per payload byte, S_ETX,
// S_CHK; S_RD reads the buffer into rdata, and S_PAY outputs that byte.
// Reset (rst, synchronous): parser hunts for STX, queue empty, out_valid low.
// Output stall: the output register holds its byte; the emitter waits, and
// the input stalls once the queue fills.
module stx_len_etx_xor_frame_echo #(
  parameter int MAX_PAYLOAD = stxecho_pkg::MaxPayloadDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       frame_last
);
  import stxecho_pkg::*;

  frame_cmd_t push_cmd;
  frame_cmd_t head;
  pay_wr_t    wr;
  logic       push;
  logic       pop;
  logic       empty;
  logic       full;

  stxecho_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte (rx_byte),
    .q_full  (full),
    .push    (push),
    .cmd     (push_cmd),
    .wr      (wr)
  );

  stxecho_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  stxecho_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_byte   (tx_byte),
    .frame_last(frame_last)
  );

endmodule

FILE: hdl/stxecho_checker.sv
// Port-level checks on the frame echo block, bound to the top level.
// Depends on stx_len_etx_xor_frame_echo_defines.svh and stxecho_pkg.
`include "stx_len_etx_xor_frame_echo_defines.svh"

module stxecho_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] tx_byte,
  input logic       frame_last
);
  import stxecho_pkg::*;

  logic at_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
    end else if (out_valid && !out_stall) begin
      at_start <= frame_last;
    end
  end

  `STXECHO_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && in_stall,
    in_valid && $stable(rx_byte), "stalled input changed")
  `STXECHO_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(tx_byte) && $stable(frame_last), "stalled output changed")
  `STXECHO_ASSERT_IMPLY(a_starts_stx, clk, rst, out_valid && at_start,
    tx_byte == StxByte, "response does not start with STX")
  `STXECHO_ASSERT_IMPLY(a_last_not_first, clk, rst, out_valid && at_start,
    !frame_last, "response ends on its first byte")

endmodule

bind stx_len_etx_xor_frame_echo stxecho_checker u_stxecho_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for stx_len_etx_xor_frame_echo: directed frame table, then random frames.
// Needs stxecho_pkg and the block; predicts each echoed byte and compares in order.
module tb_top;
  import stxecho_pkg::*;

  localparam int MaxPayload = MaxPayloadDefault;
  localparam int ItemTarget = 500;
  localparam int SettleCycles = 12;
  localparam int WatchLimit = 4000;

  typedef enum logic [2:0] {
    SEEK_STX,
    TAKE_LEN,
    TAKE_DATA,
    WANT_ETX,
    WANT_CHK
  } rx_phase_t;

  typedef enum int {
    FR_GOOD,
    FR_BAD_CHK,
    FR_BAD_ETX,
    FR_OVERSIZE
  } frame_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } echo_byte_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        typed;
    logic [2:0]  n;
    logic [31:0] resp;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] tx_byte;
  logic       frame_last;

  logic        row_typed = 1'b0;
  logic [2:0]  row_n = 3'd0;
  logic [31:0] row_resp = 32'h0;
  logic        calm = 1'b0;

  rx_phase_t  rx_ph = SEEK_STX;
  logic [7:0] rx_acc = 8'h00;
  logic [5:0] rx_len = 6'd0;
  logic [5:0] rx_cnt = 6'd0;
  logic [7:0] held_data [MaxPayload];

  echo_byte_t fresh_echo [$];
  echo_byte_t pending_echo [$];
  stim_row_t  dir_tab [$];
  int         errors = 0;
  int         frame_items = 0;
  int         quiet_cycles = 0;

  stx_len_etx_xor_frame_echo #(
    .MAX_PAYLOAD(MaxPayload)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tx_byte(tx_byte),
    .frame_last(frame_last)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 8);
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic echo_predict(input logic [7:0] b);
    echo_byte_t eb;
    logic [7:0] chk;
    int i;
    fresh_echo.delete();
    case (rx_ph)
      SEEK_STX: begin
        if (b == StxByte) begin
          rx_ph = TAKE_LEN;
          rx_acc = b;
          rx_cnt = 6'd0;
        end
      end
      TAKE_LEN: begin
        rx_acc ^= b;
        if (b > MaxPayload) begin
          rx_ph = SEEK_STX;
        end else begin
          rx_len = b[5:0];
          rx_cnt = 6'd0;
          if (b == 8'h00) rx_ph = WANT_ETX;
          else rx_ph = TAKE_DATA;
        end
      end
      TAKE_DATA: begin
        if (rx_cnt < MaxPayload) held_data[rx_cnt] = b;
        rx_acc ^= b;
        rx_cnt = rx_cnt + 6'd1;
        if (rx_cnt >= rx_len) rx_ph = WANT_ETX;
      end
      WANT_ETX: begin
        if (b == EtxByte) begin
          rx_acc ^= b;
          rx_ph = WANT_CHK;
        end else begin
          rx_ph = SEEK_STX;
        end
      end
      WANT_CHK: begin
        if (b == rx_acc) begin
          eb.last = 1'b0;
          eb.data = StxByte;
          fresh_echo.push_back(eb);
          chk = StxByte;
          eb.data = {2'b00, rx_len};
          fresh_echo.push_back(eb);
          chk ^= eb.data;
          for (i = 0; i < rx_len; i++) begin
            eb.data = held_data[i];
            fresh_echo.push_back(eb);
            chk ^= eb.data;
          end
          eb.data = EtxByte;
          fresh_echo.push_back(eb);
          chk ^= EtxByte;
          eb.data = chk;
          eb.last = 1'b1;
          fresh_echo.push_back(eb);
        end
        rx_ph = SEEK_STX;
      end
      default: rx_ph = SEEK_STX;
    endcase
  endtask

  always @(posedge clk) begin : monitor
    echo_byte_t eb;
    int k;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        echo_predict(rx_byte);
        if (row_typed) begin
          for (k = 0; k < row_n; k++) begin
            eb.data = row_resp[31 - 8 * k -: 8];
            eb.last = (k == row_n - 1);
            pending_echo.push_back(eb);
          end
        end else begin
          for (k = 0; k < fresh_echo.size(); k++) pending_echo.push_back(fresh_echo[k]);
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_echo.size() == 0) begin
          report_mismatch("unexpected tx_byte", tx_byte, 8'h00);
        end else begin
          eb = pending_echo.pop_front();
          if (tx_byte !== eb.data) report_mismatch("tx_byte", tx_byte, eb.data);
          if (frame_last !== eb.last) begin
            report_mismatch("frame_last", {7'd0, frame_last}, {7'd0, eb.last});
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("[stx_len_etx_xor_frame_echo] ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic typed, input logic [2:0] n,
                           input logic [31:0] resp);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    row_typed <= typed;
    row_n <= n;
    row_resp <= resp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_item(input logic [7:0] b);
    send_byte(b, 1'b0, 3'd0, 32'h0);
    frame_items++;
  endtask

  task automatic add_row(input logic [7:0] b, input logic typed, input logic [2:0] n,
                         input logic [31:0] resp);
    stim_row_t r;
    r.b = b;
    r.typed = typed;
    r.n = n;
    r.resp = resp;
    dir_tab.push_back(r);
  endtask

  // hold input low until every pending response byte has left
  task automatic drain_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_echo.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_frame(input frame_kind_t kind, input int len);
    logic [7:0] acc;
    logic [7:0] b;
    int i;
    send_item(StxByte);
    acc = StxByte;
    if (kind == FR_OVERSIZE) b = 8'($urandom_range(255, MaxPayload + 1));
    else b = 8'(len);
    send_item(b);
    acc ^= b;
    if (kind == FR_OVERSIZE) return;
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      send_item(b);
      acc ^= b;
    end
    if (kind == FR_BAD_ETX) begin
      do b = 8'($urandom_range(255)); while (b == EtxByte);
      send_item(b);
      return;
    end
    send_item(EtxByte);
    acc ^= EtxByte;
    if (kind == FR_BAD_CHK) acc ^= 8'h01 << $urandom_range(7);
    send_item(acc);
  endtask

  initial begin : stimulus
    frame_kind_t kind;
    logic [7:0] b;
    int len;
    int r;
    int frames;

    add_row(8'hFF, 1'b1, 3'd0, 32'h0);
    add_row(8'h00, 1'b1, 3'd0, 32'h0);
    add_row(8'h02, 1'b0, 3'd0, 32'h0);
    add_row(8'h00, 1'b0, 3'd0, 32'h0);
    add_row(8'h03, 1'b0, 3'd0, 32'h0);
    add_row(8'h01, 1'b1, 3'd4, 32'h02000301);
    add_row(8'h02, 1'b0, 3'd0, 32'h0);
    add_row(8'hFF, 1'b1, 3'd0, 32'h0);
    add_row(8'h02, 1'b0, 3'd0, 32'h0);
    add_row(8'h3D, 1'b1, 3'd0, 32'h0);
    add_row(8'h02, 1'b0, 3'd0, 32'h0);
    add_row(8'h00, 1'b0, 3'd0, 32'h0);
    add_row(8'h02, 1'b1, 3'd0, 32'h0);
    add_row(8'h00, 1'b1, 3'd0, 32'h0);
    add_row(8'h03, 1'b1, 3'd0, 32'h0);
    add_row(8'h01, 1'b1, 3'd0, 32'h0);
    add_row(8'h02, 1'b0, 3'd0, 32'h0);
    add_row(8'h00, 1'b0, 3'd0, 32'h0);
    add_row(8'h03, 1'b0, 3'd0, 32'h0);
    add_row(8'h00, 1'b1, 3'd0, 32'h0);
    add_row(8'h02, 1'b0, 3'd0, 32'h0);
    add_row(8'h01, 1'b0, 3'd0, 32'h0);
    add_row(8'h02, 1'b0, 3'd0, 32'h0);
    add_row(8'h03, 1'b0, 3'd0, 32'h0);
    add_row(8'h02, 1'b0, 3'd0, 32'h0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].n, dir_tab[i].resp);
    end
    drain_wait();

    frames = 0;
    frame_items = 0;
    while (frame_items < ItemTarget) begin
      calm = (frame_items >= 200 && frame_items < 320);
      if (frames == 15) drain_wait();
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom_range(255));
          if (b == StxByte && $urandom_range(3) != 0) b = 8'hFF;
          send_byte(b, 1'b0, 3'd0, 32'h0);
        end
      end
      r = $urandom_range(99);
      if (r < 5) len = MaxPayload;
      else if (r < 12) len = $urandom_range(MaxPayload);
      else len = $urandom_range(8);
      r = $urandom_range(99);
      if (r < 70) kind = FR_GOOD;
      else if (r < 80) kind = FR_BAD_CHK;
      else if (r < 90) kind = FR_BAD_ETX;
      else kind = FR_OVERSIZE;
      send_frame(kind, len);
      frames++;
    end
    calm = 1'b0;

    drain_wait();
    if (errors == 0) begin
      $display("[stx_len_etx_xor_frame_echo] OK");
    end else begin
      $display("[stx_len_etx_xor_frame_echo] ERROR");
    end
    $finish;
  end

endmodule
